// ===== sv/dll_pkg.sv =====
// Package for the doubly linked list engine: request/result types and codes.
// No dependencies.
`timescale 1ns / 1ps
package dll_pkg;
  typedef enum logic [2:0] {
    OP_INS_FRONT = 3'd0,
    OP_INS_AFTER = 3'd1,
    OP_INS_BACK  = 3'd2,
    OP_DEL_FRONT = 3'd3,
    OP_DEL_KEY   = 3'd4,
    OP_DEL_BACK  = 3'd5,
    OP_SEARCH    = 3'd6,
    OP_NOP       = 3'd7
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOTFOUND = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef struct packed {
    logic [2:0]         opcode;
    logic signed [31:0] key;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [4:0]         count;
    logic signed [31:0] total;
  } res_t;
endpackage

// ===== sv/doubly_linked_list_engine.sv =====
// Doubly linked list engine: node pool in memories with registered read data; depends on dll_pkg.
// Full, empty or unused opcode: straight to the result. Front/back removal: read node, unlink.
// Insert: allocate, (for a freed node) read its free-list link, then link. A key walk reads and
// compares node by node, at most POOL_NODES nodes. One request at a time: the next one is taken
// at the edge that takes the result; the receiver cannot stall.
// Reset (rst, synchronous) empties the list and free list; node memories are not cleared.
`timescale 1ns / 1ps
module doubly_linked_list_engine #(
  parameter int POOL_NODES = 16,
  parameter int DATA_BITS  = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  dll_pkg::req_t req,
  output logic          busy,
  output logic          done,
  output dll_pkg::res_t res
);
  localparam int IW = $clog2(POOL_NODES + 1);
  localparam int AW = (POOL_NODES > 1) ? $clog2(POOL_NODES) : 1;
  localparam logic [IW-1:0] NIL = IW'(POOL_NODES);

  typedef enum logic [3:0] {
    S_IDLE, S_WALK_RD, S_WALK_CMP, S_LINK, S_UNLINK_RD, S_UNLINK_GO, S_ALLOC_RD,
    S_ALLOC_GO, S_NEXT_RD, S_NEXT_GO, S_DONE
  } state_t;

  // node memories, read data registered
  logic [DATA_BITS-1:0] mem_val [POOL_NODES];
  logic [IW-1:0]        mem_nxt [POOL_NODES];
  logic [IW-1:0]        mem_prv [POOL_NODES];
  logic [DATA_BITS-1:0] rd_val;
  logic [IW-1:0]        rd_nxt, rd_prv;
  logic [AW-1:0]        rd_addr;
  logic                 rd_en;

  state_t               state;
  dll_pkg::opcode_t     op;
  logic [DATA_BITS-1:0] kd, vd;
  logic [IW-1:0]        head, tail, free_head, fresh, cur, lp, ln, newx;
  logic [IW-1:0]        steps;
  logic [IW-1:0]        count;
  logic [31:0]          sum;
  logic [1:0]           status;
  logic                 wait_rd;

  function automatic logic [31:0] sext(input logic [DATA_BITS-1:0] d);
    return 32'(signed'(d));
  endfunction

  function automatic logic in_pool(input logic [IW-1:0] i);
    return i < NIL;
  endfunction

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_val <= mem_val[rd_addr];
      rd_nxt <= mem_nxt[rd_addr];
      rd_prv <= mem_prv[rd_addr];
    end
  end

  // sequential write ports are driven from the control block below
  logic                 wv_en, wn_en, wp_en, wn2_en, wp2_en;
  logic [AW-1:0]        wv_a, wn_a, wp_a, wn2_a, wp2_a;
  logic [DATA_BITS-1:0] wv_d;
  logic [IW-1:0]        wn_d, wp_d, wn2_d, wp2_d;

  always_ff @(posedge clk) begin
    if (wv_en) mem_val[wv_a] <= wv_d;
    if (wn_en) mem_nxt[wn_a] <= wn_d;
    if (wn2_en) mem_nxt[wn2_a] <= wn2_d;
    if (wp_en) mem_prv[wp_a] <= wp_d;
    if (wp2_en) mem_prv[wp2_a] <= wp2_d;
  end

  // memory access decode per state
  always_comb begin
    rd_en = 1'b0; rd_addr = cur[AW-1:0];
    wv_en = 1'b0; wv_a = newx[AW-1:0]; wv_d = vd;
    wn_en = 1'b0; wn_a = newx[AW-1:0]; wn_d = ln;
    wp_en = 1'b0; wp_a = newx[AW-1:0]; wp_d = lp;
    wn2_en = 1'b0; wn2_a = lp[AW-1:0]; wn2_d = newx;
    wp2_en = 1'b0; wp2_a = ln[AW-1:0]; wp2_d = newx;
    case (state)
      S_WALK_RD, S_UNLINK_RD, S_ALLOC_RD, S_NEXT_RD: rd_en = 1'b1;
      S_LINK: begin
        wv_en = 1'b1; wn_en = 1'b1; wp_en = 1'b1;
        wn2_en = in_pool(lp); wp2_en = in_pool(ln);
      end
      S_UNLINK_GO: begin
        // bypass around the unlinked node and push it on the free list
        wn2_en = in_pool(rd_prv); wn2_a = rd_prv[AW-1:0]; wn2_d = rd_nxt;
        wp2_en = in_pool(rd_nxt); wp2_a = rd_nxt[AW-1:0]; wp2_d = rd_prv;
        wn_en = 1'b1; wn_a = cur[AW-1:0]; wn_d = free_head;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; busy <= 1'b0; done <= 1'b0;
      head <= NIL; tail <= NIL; free_head <= NIL; fresh <= '0;
      count <= '0; sum <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: if (start) begin
          busy <= 1'b1;
          op <= dll_pkg::opcode_t'(req.opcode);
          kd <= DATA_BITS'(64'(signed'(req.key)));
          vd <= DATA_BITS'(64'(signed'(req.value)));
          status <= dll_pkg::ST_OK;
          cur <= head; steps <= '0;
          case (dll_pkg::opcode_t'(req.opcode))
            dll_pkg::OP_INS_FRONT, dll_pkg::OP_INS_BACK: begin
              lp <= (req.opcode == dll_pkg::OP_INS_BACK) ? tail : NIL;
              ln <= (req.opcode == dll_pkg::OP_INS_BACK) ? NIL : head;
              state <= S_ALLOC_RD;
              if (count >= NIL) begin
                status <= dll_pkg::ST_FULL; state <= S_DONE;
              end
            end
            dll_pkg::OP_DEL_FRONT, dll_pkg::OP_DEL_BACK: begin
              cur <= (req.opcode == dll_pkg::OP_DEL_BACK) ? tail : head;
              state <= S_UNLINK_RD;
              if (!in_pool(head)) begin
                status <= dll_pkg::ST_EMPTY; state <= S_DONE;
              end
            end
            dll_pkg::OP_INS_AFTER, dll_pkg::OP_DEL_KEY, dll_pkg::OP_SEARCH:
              state <= S_WALK_RD;
            default: state <= S_DONE;
          endcase
        end
        S_WALK_RD: begin
          if (!in_pool(cur) || steps >= NIL) begin
            status <= dll_pkg::ST_NOTFOUND; state <= S_DONE;
          end else state <= S_WALK_CMP;
        end
        S_WALK_CMP: begin
          if (rd_val == kd) begin
            case (op)
              dll_pkg::OP_SEARCH: state <= S_DONE;
              dll_pkg::OP_DEL_KEY: state <= S_UNLINK_RD;
              default: begin
                lp <= cur; ln <= rd_nxt; state <= S_ALLOC_RD;
                if (count >= NIL) begin
                  status <= dll_pkg::ST_FULL; state <= S_DONE;
                end
              end
            endcase
          end else begin
            cur <= rd_nxt; steps <= steps + 1'b1; state <= S_WALK_RD;
          end
        end
        S_ALLOC_RD: begin
          // take from the free list (needs its next link) else a fresh node
          if (in_pool(free_head)) begin
            cur <= free_head; newx <= free_head; state <= S_NEXT_RD;
          end else begin
            newx <= fresh; fresh <= fresh + 1'b1; state <= S_LINK;
          end
        end
        S_NEXT_RD: state <= S_NEXT_GO;
        S_NEXT_GO: begin
          free_head <= rd_nxt; state <= S_LINK;
        end
        S_LINK: begin
          if (!in_pool(lp)) head <= newx;
          if (!in_pool(ln)) tail <= newx;
          count <= count + 1'b1;
          sum <= sum + sext(vd);
          state <= S_DONE;
        end
        S_UNLINK_RD: state <= S_UNLINK_GO;
        S_UNLINK_GO: begin
          if (!in_pool(rd_prv)) head <= rd_nxt;
          if (!in_pool(rd_nxt)) tail <= rd_prv;
          sum <= sum - sext(rd_val);
          if (count != '0) count <= count - 1'b1;
          free_head <= cur;
          state <= S_DONE;
        end
        S_DONE: begin
          done <= 1'b1; busy <= 1'b0;
          res.status <= status;
          res.count <= 5'(count);
          res.total <= sum;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // unused state code guard
  assign wait_rd = (state == S_ALLOC_GO);

  a_count_range: assert property (@(posedge clk) disable iff (rst) count <= NIL)
    else $error("node count beyond pool");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe longer than one cycle");
  a_empty_links: assert property (@(posedge clk) disable iff (rst)
    (count == '0 && state == S_IDLE) |-> (head == NIL && tail == NIL))
    else $error("empty list with live head or tail");
  a_no_alloc_wait: assert property (@(posedge clk) disable iff (rst) !wait_rd)
    else $error("reached unused state");
endmodule
